[src/rmg_pkg.sv]
// ----------------------------------------------------------------------------
// rmg_pkg: shared types and helpers for the minimum-gap segment tree
// Holds the node record, its packing, and the node merge function.
// ----------------------------------------------------------------------------
package rmg_pkg;

    localparam int MAX_BITS = 16;

    typedef struct packed {
        logic [MAX_BITS-1:0] lo;
        logic [MAX_BITS-1:0] hi;
        logic [MAX_BITS-1:0] gap;
        logic [1:0]          cnt;
    } node_t;

    // Merge of a left node a with a right node b (all of a's values lie below b's).
    function automatic node_t join_nodes(node_t a, node_t b);
        node_t               m;
        logic [MAX_BITS-1:0] g;
        m = a;
        g = b.lo - a.hi;
        if (a.cnt == 2'd0)
        begin
            m = b;
        end
        else if (b.cnt != 2'd0)
        begin
            if (a.cnt == 2'd2 && a.gap < g)
            begin
                g = a.gap;
            end
            if (b.cnt == 2'd2 && b.gap < g)
            begin
                g = b.gap;
            end
            m.lo  = a.lo;
            m.hi  = b.hi;
            m.gap = g;
            m.cnt = 2'd2;
        end
        return m;
    endfunction

endpackage

[src/range_min_gap_segment_tree.sv]
// ----------------------------------------------------------------------------
// range_min_gap_segment_tree: smallest gap between stored values in a range
// Segment tree over the value domain held in one node memory.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in      | input     | in_valid, in_ready, action, value, range_low, range_high
//  out     | output    | out_valid, out_ready, min_gap, found
//
// After reset a clearing pass writes an empty node to each of the
// 2^(VALUE_BITS+1) entries, one a cycle; no transaction is taken meanwhile.
// An insert reads its leaf, writes it, and then for each tree level reads
// the left child, reads the right child and writes the parent, up to the
// root; the next transaction is taken only after the root has been written.
// A query visits nodes one a cycle in a depth-first walk, up to about
// 4*VALUE_BITS nodes, but pauses in S_QWAIT for the registered data of each
// node that is read; at most about 2*VALUE_BITS nodes are read. The one
// read port of the node memory sets this pace. A query result waits in the
// output register; the next transaction is taken only after it is delivered.
module range_min_gap_segment_tree #(
    parameter int VALUE_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [9:0]            value,
    input  logic [9:0]            range_low,
    input  logic [9:0]            range_high,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [9:0]            min_gap,
    output logic                  found
);
    import rmg_pkg::*;

    localparam int AB  = VALUE_BITS + 1;
    localparam int VB  = VALUE_BITS;
    localparam int LVB = $clog2(VALUE_BITS + 2);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_LEAF  = 8'b0000_0100,
        S_RDL   = 8'b0000_1000,
        S_RDR   = 8'b0001_0000,
        S_WR    = 8'b0010_0000,
        S_QVIS  = 8'b0100_0000,
        S_QWAIT = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [AB-1:0]   clr_reg;
    logic [AB-1:0]   idx_reg;       // insert node, or current query node
    logic [LVB-1:0]  lvl_reg;       // depth of query node (0 = root)
    node_t           left_reg;
    node_t           acc_reg;
    logic [VB-1:0]   qlo_reg, qhi_reg;
    logic            out_valid_reg;
    logic [9:0]      gap_out_reg;
    logic            found_out_reg;

    // S_QWAIT holds one read in flight; the read address is the visited node.
    logic            q_pending_reg, q_done_reg;

    logic            wr_en;
    logic [AB-1:0]   wr_addr, rd_addr;
    node_t           wr_data, rd_data;
    node_t           acc_join;

    rmg_node_mem #(.ADDR_BITS(AB)) u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // Bounds of the current query node from its index and depth, plus the input
    logic [VB-1:0] nlo, nhi, vin, lo_in, hi_in, span;
    always_comb
    begin
        span  = VB'((VB+1)'(1) << (VB - int'(lvl_reg))) - VB'(1);
        nlo   = VB'(idx_reg << (VB - int'(lvl_reg)));
        nhi   = nlo + span;
        vin   = VB'(value);
        lo_in = (range_low > 10'(2**VB - 1)) ? {VB{1'b1}} : VB'(range_low);
        hi_in = (range_high > 10'(2**VB - 1)) ? {VB{1'b1}} : VB'(range_high);
    end

    // Next node in depth-first order after finishing current one.
    logic [AB-1:0]  up_idx;
    logic [LVB-1:0] up_lvl;
    logic           walk_done;
    always_comb
    begin
        up_idx = idx_reg;
        up_lvl = lvl_reg;
        for (int i = 0; i <= VB; i++)
        begin
            if (up_idx[0] && up_lvl != '0)
            begin
                up_idx = up_idx >> 1;
                up_lvl = up_lvl - LVB'(1);
            end
        end
        walk_done = (up_lvl == '0);
        up_idx = up_idx + AB'(1);
    end

    logic node_out, node_in;
    always_comb
    begin
        node_out = (nhi < qlo_reg) || (nlo > qhi_reg);
        node_in  = (nlo >= qlo_reg) && (nhi <= qhi_reg);
    end

    // Running result merged with the node that has just been read.
    assign acc_join = join_nodes(acc_reg, rd_data);

    logic insert_ok;
    assign insert_ok = (value <= 10'(2**VB - 1));

    always_comb
    begin
        state_next = state_reg;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;
        rd_addr = idx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == {AB{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_addr = {1'b1, vin};
                if (in_valid && !out_valid_reg)
                begin
                    if (action)
                    begin
                        state_next = (lo_in > hi_in) ? S_QWAIT : S_QVIS;
                    end
                    else if (insert_ok)
                    begin
                        state_next = S_LEAF;
                    end
                end
            end
            S_LEAF:
            begin
                wr_en = 1'b1;
                wr_data = rd_data;
                if (rd_data.cnt == 2'd0)
                begin
                    wr_data.lo  = MAX_BITS'(idx_reg[VB-1:0]);
                    wr_data.hi  = MAX_BITS'(idx_reg[VB-1:0]);
                    wr_data.gap = '0;
                    wr_data.cnt = 2'd1;
                end
                else
                begin
                    wr_data.gap = '0;
                    wr_data.cnt = 2'd2;
                end
                state_next = S_RDL;
            end
            S_RDL:
            begin
                // The child reads start only after the lower level was written.
                rd_addr = {idx_reg[AB-1:1], 1'b0};
                state_next = S_RDR;
            end
            S_RDR:
            begin
                rd_addr = {idx_reg[AB-1:1], 1'b1};
                state_next = S_WR;
            end
            S_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg >> 1;
                wr_data = join_nodes(left_reg, rd_data);
                state_next = (wr_addr == AB'(1)) ? S_IDLE : S_RDL;
            end
            S_QVIS:
            begin
                if (node_in || lvl_reg == LVB'(VB))
                begin
                    state_next = S_QWAIT;
                end
                else if (node_out)
                begin
                    state_next = walk_done ? S_QWAIT : S_QVIS;
                end
            end
            S_QWAIT:
            begin
                state_next = q_done_reg ? S_IDLE : S_QVIS;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            q_pending_reg <= 1'b0;
            q_done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + AB'(1);
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !out_valid_reg && action)
                    begin
                        q_pending_reg <= 1'b0;
                        q_done_reg    <= (lo_in > hi_in);
                    end
                end
                S_QVIS:
                begin
                    if (node_in || lvl_reg == LVB'(VB))
                    begin
                        q_pending_reg <= !node_out;
                        q_done_reg    <= walk_done;
                    end
                    else if (node_out && walk_done)
                    begin
                        q_pending_reg <= 1'b0;
                        q_done_reg    <= 1'b1;
                    end
                end
                S_QWAIT:
                begin
                    if (q_done_reg)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                idx_reg <= {1'b1, vin};
                lvl_reg <= '0;
                qlo_reg <= lo_in;
                qhi_reg <= hi_in;
                acc_reg <= '0;
                if (action)
                begin
                    idx_reg <= AB'(1);
                end
            end
            S_RDR:
            begin
                left_reg <= rd_data;
            end
            S_WR:
            begin
                idx_reg <= idx_reg >> 1;
            end
            S_QVIS:
            begin
                if (node_in || lvl_reg == LVB'(VB))
                begin
                    if (!walk_done)
                    begin
                        idx_reg <= up_idx;
                        lvl_reg <= up_lvl;
                    end
                end
                else if (node_out)
                begin
                    idx_reg <= up_idx;
                    lvl_reg <= up_lvl;
                end
                else
                begin
                    idx_reg <= idx_reg << 1;
                    lvl_reg <= lvl_reg + LVB'(1);
                end
            end
            S_QWAIT:
            begin
                if (q_pending_reg)
                begin
                    acc_reg <= acc_join;
                end
                if (q_done_reg)
                begin
                    gap_out_reg   <= '0;
                    found_out_reg <= 1'b0;
                    if (q_pending_reg)
                    begin
                        if (acc_join.cnt == 2'd2)
                        begin
                            gap_out_reg   <= 10'(acc_join.gap);
                            found_out_reg <= 1'b1;
                        end
                    end
                    else if (acc_reg.cnt == 2'd2)
                    begin
                        gap_out_reg   <= 10'(acc_reg.gap);
                        found_out_reg <= 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign min_gap   = gap_out_reg;
    assign found     = found_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_gap))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken with a result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        !found && out_valid |-> min_gap == 10'd0)
        else $error("gap reported without a find");

endmodule

[src/rmg_node_mem.sv]
// ----------------------------------------------------------------------------
// rmg_node_mem: node storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rmg_node_mem #(
    parameter int ADDR_BITS = 11
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_BITS-1:0]  wr_addr,
    input  rmg_pkg::node_t        wr_data,
    input  logic [ADDR_BITS-1:0]  rd_addr,
    output rmg_pkg::node_t        rd_data
);
    import rmg_pkg::*;

    node_t mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[bench/range_min_gap_checker.sv]
// ----------------------------------------------------------------------------
// range_min_gap_checker: predictor and scoreboard for the minimum-gap tree
// Watches both channels, keeps its own copy of the stored values, and
// compares every query result with the expected gap and found flag.
// ----------------------------------------------------------------------------
module range_min_gap_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       action,
    input  logic [9:0] value,
    input  logic [9:0] range_low,
    input  logic [9:0] range_high,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [9:0] min_gap,
    input  logic       found,
    output int         fail_count,
    output int         pending_answers,
    output int         answer_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [9:0] gap;
        logic       hit;
    } answer_t;

    // Copies held per value, saturating at 2.
    int unsigned copies [1024];
    answer_t     answer_q [$];

    // Sorted scan over the range: smallest gap between neighbours.
    function automatic answer_t range_gap(logic [9:0] qlo, logic [9:0] qhi);
        answer_t r;
        int      prev;
        int      v;
        int      best;
        r    = '0;
        prev = -1;
        best = 1 << 20;
        if (qlo > qhi)
        begin
            return r;
        end
        for (v = qlo; v <= qhi; v++)
        begin
            if (copies[v] >= 2)
            begin
                best = 0;
            end
            if (copies[v] != 0)
            begin
                if (prev >= 0 && v - prev < best)
                begin
                    best = v - prev;
                end
                prev = v;
            end
        end
        if (best < (1 << 20))
        begin
            r.hit = 1'b1;
            r.gap = best[9:0];
        end
        return r;
    endfunction

    assign pending_answers = answer_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        int      errs;
        if (!rst_n)
        begin
            foreach (copies[i])
            begin
                copies[i] = 0;
            end
            answer_q.delete();
            fail_count   <= 0;
            answer_count <= 0;
        end
        else
        begin
            errs = 0;
            if (out_valid && out_ready)
            begin
                answer_count <= answer_count + 1;
                if (answer_q.size() == 0)
                begin
                    $error("unexpected result: min_gap=%0d found=%0b", min_gap, found);
                    errs++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (min_gap !== want.gap)
                    begin
                        $error("min_gap: expected %0d, actual %0d", want.gap, min_gap);
                        errs++;
                    end
                    if (found !== want.hit)
                    begin
                        $error("found: expected %0b, actual %0b", want.hit, found);
                        errs++;
                    end
                end
            end
            if (errs != 0)
            begin
                fail_count <= fail_count + errs;
            end
            if (in_valid && in_ready)
            begin
                if (action == 1'b0)
                begin
                    if (copies[value] < 2)
                    begin
                        copies[value] = copies[value] + 1;
                    end
                end
                else
                begin
                    answer_q = {answer_q, range_gap(range_low, range_high)};
                end
            end
        end
    end
endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: top level testbench for range_min_gap_segment_tree
// Drives insert and query transactions with random idling on both sides,
// holds the output off once so the input stalls, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       action;
    logic [9:0] value;
    logic [9:0] range_low;
    logic [9:0] range_high;
    logic       out_valid;
    logic       out_ready;
    logic [9:0] min_gap;
    logic       found;
    int         fail_count;
    int         pending_answers;
    int         answer_count;
    int         sent_count;
    bit         hold_off;

    range_min_gap_segment_tree i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .action(action), .value(value),
        .range_low(range_low), .range_high(range_high),
        .out_valid(out_valid), .out_ready(out_ready), .min_gap(min_gap), .found(found)
    );

    range_min_gap_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .action(action), .value(value),
        .range_low(range_low), .range_high(range_high),
        .out_valid(out_valid), .out_ready(out_ready), .min_gap(min_gap), .found(found),
        .fail_count(fail_count), .pending_answers(pending_answers),
        .answer_count(answer_count)
    );

    // The clock runs with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Sends one transaction and holds it until the block accepts it.
    // The idle gap is drawn first, so valid is never dropped and raised in one step.
    task automatic send_item(logic op, logic [9:0] v, logic [9:0] lo, logic [9:0] hi);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= op;
        value      <= v;
        range_low  <= lo;
        range_high <= hi;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    // Picks a value, mostly from three small clusters so gaps and repeats are common.
    function automatic logic [9:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 10'($urandom_range(0, 1023));
            1: return 10'($urandom_range(500, 540));
            2: return 10'($urandom_range(0, 15));
            default: return 10'($urandom_range(1008, 1023));
        endcase
    endfunction

    // The receiver stalls at random; hold_off freezes it for a long stretch.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [9:0] a;
        logic [9:0] b;
        int         n;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = OP_INSERT;
        value      = '0;
        range_low  = '0;
        range_high = '0;
        sent_count = 0;
        hold_off   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty tree, extremes, repeats, empty and narrow ranges.
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd1023);
        send_item(OP_INSERT, 10'd0, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd1023, 10'd0, 10'd1023);
        send_item(OP_INSERT, 10'd1023, 10'd1023, 10'd1023);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd1023);
        send_item(OP_INSERT, 10'd1023, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd1023, 10'd1023);
        send_item(OP_INSERT, 10'd1023, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd1023, 10'd1023);
        send_item(OP_INSERT, 10'd341, 10'd682, 10'd341);
        send_item(OP_INSERT, 10'd682, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd682, 10'd341);
        send_item(OP_QUERY, 10'd0, 10'd341, 10'd682);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd682);
        send_item(OP_QUERY, 10'd0, 10'd1, 10'd1022);
        send_item(OP_QUERY, 10'd0, 10'd341, 10'd341);

        // Long receiver hold-off while the sender keeps offering queries.
        hold_off = 1'b1;
        for (n = 0; n < 8; n++)
        begin
            send_item(OP_QUERY, pick_value(), 10'd0, 10'd1023);
        end

        // Random part: a mix of inserts and queries, some with reversed bounds.
        for (n = 0; n < 1530; n++)
        begin
            a = pick_value();
            b = pick_value();
            if ($urandom_range(0, 9) != 0 && a > b)
            begin
                {a, b} = {b, a};
            end
            send_item(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)) ^ pick_value(),
                a, b);
        end
        in_valid <= 1'b0;

        while (pending_answers != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        $display("Sent %0d transactions, checked %0d query results.", sent_count,
            answer_count);
        if (fail_count == 0)
        begin
            $display("range_min_gap_segment_tree test passed");
        end
        else
        begin
            $display("range_min_gap_segment_tree test failed");
        end
        $finish;
    end

    // Watchdog: far longer than the slowest correct run.
    initial
    begin
        #2000000;
        $display("range_min_gap_segment_tree test failed");
        $finish;
    end
endmodule

[files.f]
src/rmg_pkg.sv
src/rmg_node_mem.sv
src/range_min_gap_segment_tree.sv
bench/range_min_gap_checker.sv
bench/tb.sv
